FILE: hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock outside reset
`define HRP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hrp assertion failed");

// checked during reset too
`define HRP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("hrp reset assertion failed");

`endif

FILE: hdl/hrp_pkg.sv
// types, constants and helpers of the http request header parser
// no dependencies
package hrp_pkg;

    localparam int HRP_HEADER_SLOTS = 16;
    localparam int HRP_BUFFER_BYTES = 4096;
    localparam int HRP_MAX_RES      = 4;
    localparam int HRP_QUEUE_DEPTH  = 4;

    localparam logic [3:0] EV_VERB    = 4'd0;
    localparam logic [3:0] EV_PATH    = 4'd1;
    localparam logic [3:0] EV_VERSION = 4'd2;
    localparam logic [3:0] EV_CONN    = 4'd3;
    localparam logic [3:0] EV_CTYPE   = 4'd4;
    localparam logic [3:0] EV_CLEN    = 4'd5;
    localparam logic [3:0] EV_OTHER   = 4'd6;
    localparam logic [3:0] EV_OK      = 4'd7;
    localparam logic [3:0] EV_FAIL    = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [7:0] PFX_TXT [3][15] = '{
        '{"c","o","n","n","e","c","t","i","o","n",":",8'h00,8'h00,8'h00,8'h00},
        '{"c","o","n","t","e","n","t","-","t","y","p","e",":",8'h00,8'h00},
        '{"c","o","n","t","e","n","t","-","l","e","n","g","t","h",":"}
    };
    localparam logic [4:0] PFX_LEN [3] = '{5'd11, 5'd13, 5'd15};

    typedef enum logic [2:0] {
        PH_BEFORE, PH_VSKIP, PH_VERB, PH_PSKIP, PH_PATH, PH_VERSION, PH_HEADERS, PH_HALT
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]         event_kind;
        logic [11:0]        field_offset;
        logic [12:0]        field_length;
        logic signed [31:0] numeric_value;
        logic [3:0]         header_slot;
        logic               run_end;
    } t_out;

    typedef struct packed {
        logic [2:0] count;
        t_out [HRP_MAX_RES-1:0] res;
    } t_bundle;

    function automatic logic [7:0] fold(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

    function automatic t_out mk(input logic [3:0] kind, input logic [31:0] off,
                                input logic [31:0] len, input logic [31:0] num,
                                input logic [31:0] slot);
        t_out r;
        r.event_kind    = kind;
        r.field_offset  = off[11:0];
        r.field_length  = len[12:0];
        r.numeric_value = num;
        r.header_slot   = slot[3:0];
        r.run_end       = 1'b0;
        return r;
    endfunction

endpackage

FILE: hdl/hrp_front.sv
// front end: parser state, turns each accepted byte into a bundle of results
// depends on hrp_pkg
module hrp_front
    import hrp_pkg::*;
#(
    parameter int HEADER_SLOTS = HRP_HEADER_SLOTS,
    parameter int BUFFER_BYTES = HRP_BUFFER_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in     i_item,
    output t_bundle o_bundle
);
    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam int HW = $clog2(HEADER_SLOTS);

    logic [PW-1:0] r_pos, n_pos;
    t_phase        r_phase, n_phase;
    logic [PW-1:0] r_m0, n_m0, r_m1, n_m1, r_m2, n_m2, r_m3, n_m3, r_m4, n_m4, r_m5, n_m5;
    logic [4:0]    r_col, n_col;
    logic [2:0]    r_cand, n_cand;
    logic [PW-1:0] r_vfirst, n_vfirst, r_vlast, n_vlast;
    logic [31:0]   r_acc, n_acc;
    logic [1:0]    r_ss, n_ss;
    logic [31:0]   r_clen, n_clen;
    logic [HW-1:0] r_hcnt, n_hcnt;
    logic [1:0]    r_vstep, n_vstep;
    logic          r_vseen, n_vseen;

    always_comb begin
        logic [7:0]    ch;
        logic          run, over, closech, do_close, finf, ok, hit, first;
        logic [PW-1:0] e;
        logic [2:0]    cnt;
        logic [35:0]   m;
        logic [31:0]   v;
        logic [4:0]    c;
        t_bundle       b;
        n_pos = r_pos; n_phase = r_phase;
        n_m0 = r_m0; n_m1 = r_m1; n_m2 = r_m2; n_m3 = r_m3; n_m4 = r_m4; n_m5 = r_m5;
        n_col = r_col; n_cand = r_cand; n_vfirst = r_vfirst; n_vlast = r_vlast;
        n_acc = r_acc; n_ss = r_ss; n_clen = r_clen; n_hcnt = r_hcnt;
        n_vstep = r_vstep; n_vseen = r_vseen;
        b = '0;
        cnt = 3'd0;
        ch = i_item.data_byte;
        run = r_phase != PH_HALT;
        over = r_pos >= PW'(BUFFER_BYTES);
        closech = ch == CH_NUL || ch == CH_CR || ch == CH_LF;
        ok = 1'b0; hit = 1'b0; first = 1'b0; m = '0; v = '0; c = '0; e = '0;
        if (run && over) begin
            b.res[cnt[1:0]] = mk(EV_FAIL, 0, 0, n_clen, 32'(n_hcnt)); cnt = cnt + 3'd1;
            n_phase = PH_HALT;
        end else if (run && !closech) begin
            if (n_phase == PH_BEFORE) n_phase = PH_VSKIP;
            case (n_phase)
                PH_VSKIP: if (ch != CH_SPACE) begin n_m0 = r_pos; n_phase = PH_VERB; end
                PH_VERB: if (ch == CH_SPACE) begin
                    b.res[cnt[1:0]] = mk(EV_VERB, 32'(r_m0), 32'(r_pos) - 32'(r_m0), 0, 0);
                    cnt = cnt + 3'd1;
                    n_phase = PH_PSKIP;
                end
                PH_PSKIP: if (ch != CH_SPACE) begin n_m1 = r_pos; n_phase = PH_PATH; end
                PH_PATH: if (ch == CH_SPACE) begin
                    b.res[cnt[1:0]] = mk(EV_PATH, 32'(r_m1), 32'(r_pos) - 32'(r_m1), 0, 0);
                    cnt = cnt + 3'd1;
                    n_phase = PH_VERSION;
                    n_vstep = 2'd0;
                end
                PH_VERSION: begin
                    if (r_vstep == 2'd0) begin
                        if (ch != CH_SLASH) begin n_m2 = r_pos; n_vstep = 2'd1; end
                    end else if (r_vstep == 2'd1 && ch == CH_SLASH) begin
                        n_m3 = r_pos;
                        n_m4 = r_pos + PW'(1);
                        n_vstep = 2'd2;
                    end
                end
                PH_HEADERS: begin
                    c = r_col;
                    if (c == 5'd0) begin
                        n_m5 = r_pos; n_cand = 3'b111; n_vseen = 1'b0;
                        n_vfirst = '0; n_vlast = '0; n_acc = '0; n_ss = '0;
                    end
                    for (int k = 0; k < 3; k++) begin
                        if (n_cand[k]) begin
                            if (c < PFX_LEN[k]) begin
                                if (fold(ch) != PFX_TXT[k][c[3:0]]) n_cand[k] = 1'b0;
                            end else if (!is_blank(ch)) begin
                                first = !n_vseen;
                                if (first) begin n_vfirst = r_pos; n_vseen = 1'b1; end
                                n_vlast = r_pos;
                                // atoi style conversion, magnitude saturates at 2^31
                                if (k == 2 && !n_ss[1]) begin
                                    if (first && (ch == CH_PLUS || ch == CH_MINUS)) begin
                                        if (ch == CH_MINUS) n_ss[0] = 1'b1;
                                    end else if (ch >= "0" && ch <= "9") begin
                                        m = {n_acc, 3'b000} + {2'b00, n_acc, 1'b0}
                                            + 36'(ch - "0");
                                        n_acc = (m > 36'h080000000) ? 32'h80000000 : m[31:0];
                                    end else begin
                                        n_ss[1] = 1'b1;
                                    end
                                end
                            end else if (k == 2 && n_vseen) begin
                                n_ss[1] = 1'b1;
                            end
                        end
                    end
                    n_col = (c < 5'd31) ? c + 5'd1 : 5'd31;
                end
                default: ;
            endcase
        end
        // at most two line closes per byte: the byte itself, then the final flag
        for (int s = 0; s < 2; s++) begin
            if (s == 0) begin
                do_close = run && !over && closech;
                e = r_pos;
                finf = ch == CH_NUL;
            end else begin
                do_close = run && i_item.final_byte && n_phase != PH_HALT;
                e = r_pos + PW'(1);
                finf = 1'b1;
            end
            if (do_close) begin
                ok = 1'b0;
                if (finf && n_phase == PH_BEFORE) begin
                    b.res[cnt[1:0]] = mk(EV_FAIL, 0, 0, n_clen, 32'(n_hcnt));
                    cnt = cnt + 3'd1;
                end else if (n_phase == PH_HEADERS) begin
                    if (n_col == 5'd0) begin
                        ok = 1'b1;
                    end else begin
                        hit = 1'b0;
                        if (n_ss[0]) v = 32'd0 - n_acc;
                        else v = (n_acc > 32'h7fffffff) ? 32'h7fffffff : n_acc;
                        for (int k = 0; k < 3; k++) begin
                            if (!hit && n_cand[k] && n_col >= PFX_LEN[k]) begin
                                if (k == 2) n_clen = v;
                                b.res[cnt[1:0]] = mk(EV_CONN + 4'(k),
                                    n_vseen ? 32'(n_vfirst) : 32'(e),
                                    n_vseen ? 32'(n_vlast) - 32'(n_vfirst) + 32'd1 : 32'd0,
                                    (k == 2) ? v : 32'd0, 0);
                                cnt = cnt + 3'd1;
                                hit = 1'b1;
                            end
                        end
                        n_col = 5'd0;
                        if (hit) begin
                            ok = 1'b1;
                        end else if (32'(n_hcnt) < 32'(HEADER_SLOTS - 1)) begin
                            b.res[cnt[1:0]] = mk(EV_OTHER, 32'(n_m5), 32'(e) - 32'(n_m5),
                                                 0, 32'(n_hcnt));
                            cnt = cnt + 3'd1;
                            n_hcnt = n_hcnt + HW'(1);
                            ok = 1'b1;
                        end else begin
                            b.res[cnt[1:0]] = mk(EV_FAIL, 0, 0, n_clen, 32'(n_hcnt));
                            cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    end
                end else if (n_phase != PH_BEFORE) begin
                    case (n_phase)
                        PH_VERB: begin
                            b.res[cnt[1:0]] = mk(EV_VERB, 32'(n_m0), 32'(e) - 32'(n_m0), 0, 0);
                            cnt = cnt + 3'd1;
                            b.res[cnt[1:0]] = mk(EV_FAIL, 0, 0, n_clen, 32'(n_hcnt));
                            cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                        PH_PATH: begin
                            b.res[cnt[1:0]] = mk(EV_PATH, 32'(n_m1), 32'(e) - 32'(n_m1), 0, 0);
                            cnt = cnt + 3'd1;
                            ok = 1'b1;
                        end
                        PH_VERSION: begin
                            if (n_vstep == 2'd1) begin
                                b.res[cnt[1:0]] = mk(EV_VERSION, 32'(n_m2),
                                                     32'(e) - 32'(n_m2), 0, 0);
                                cnt = cnt + 3'd1;
                            end else if (n_vstep == 2'd2) begin
                                // empty text after the slash: fall back to the token before it
                                if (e > n_m4)
                                    b.res[cnt[1:0]] = mk(EV_VERSION, 32'(n_m4),
                                                         32'(e) - 32'(n_m4), 0, 0);
                                else
                                    b.res[cnt[1:0]] = mk(EV_VERSION, 32'(n_m2),
                                                         32'(n_m3) - 32'(n_m2), 0, 0);
                                cnt = cnt + 3'd1;
                            end
                            ok = 1'b1;
                        end
                        default: begin
                            b.res[cnt[1:0]] = mk(EV_FAIL, 0, 0, n_clen, 32'(n_hcnt));
                            cnt = cnt + 3'd1;
                            n_phase = PH_HALT;
                        end
                    endcase
                    if (ok) n_phase = PH_HEADERS;
                end
                if (finf) begin
                    if (ok) begin
                        b.res[cnt[1:0]] = mk(EV_OK, 0, 0, n_clen, 32'(n_hcnt));
                        cnt = cnt + 3'd1;
                    end
                    n_phase = PH_HALT;
                end
            end
        end
        n_pos = (r_pos < PW'(BUFFER_BYTES)) ? r_pos + PW'(1) : PW'(BUFFER_BYTES);
        if (i_item.final_byte) begin
            n_pos = '0; n_phase = PH_BEFORE;
            n_m0 = '0; n_m1 = '0; n_m2 = '0; n_m3 = '0; n_m4 = '0; n_m5 = '0;
            n_col = '0; n_cand = 3'b111; n_vfirst = '0; n_vlast = '0;
            n_acc = '0; n_ss = '0; n_clen = 32'hffffffff; n_hcnt = '0;
            n_vstep = '0; n_vseen = 1'b0;
        end
        if (cnt != 3'd0) b.res[2'(cnt - 3'd1)].run_end = 1'b1;
        b.count = cnt;
        o_bundle = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_phase <= PH_BEFORE;
            r_m0 <= '0; r_m1 <= '0; r_m2 <= '0; r_m3 <= '0; r_m4 <= '0; r_m5 <= '0;
            r_col <= '0; r_cand <= 3'b111; r_vfirst <= '0; r_vlast <= '0;
            r_acc <= '0; r_ss <= '0; r_clen <= 32'hffffffff; r_hcnt <= '0;
            r_vstep <= '0; r_vseen <= 1'b0;
        end else if (i_accept) begin
            r_pos <= n_pos; r_phase <= n_phase;
            r_m0 <= n_m0; r_m1 <= n_m1; r_m2 <= n_m2; r_m3 <= n_m3; r_m4 <= n_m4; r_m5 <= n_m5;
            r_col <= n_col; r_cand <= n_cand; r_vfirst <= n_vfirst; r_vlast <= n_vlast;
            r_acc <= n_acc; r_ss <= n_ss; r_clen <= n_clen; r_hcnt <= n_hcnt;
            r_vstep <= n_vstep; r_vseen <= n_vseen;
        end
    end

endmodule

FILE: hdl/hrp_queue.sv
// short queue of result bundles between front and back end
// depends on hrp_pkg
module hrp_queue
    import hrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_rd,
    output logic    o_valid,
    output t_bundle o_data
);
    localparam int AW = $clog2(HRP_QUEUE_DEPTH);

    t_bundle         r_mem [HRP_QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = r_cnt == (AW+1)'(HRP_QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + AW'(1);
            if (i_rd) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_wr) - (AW+1)'(i_rd);
        end
    end

endmodule

FILE: hdl/hrp_back.sv
// back end: unpacks bundles into single result beats on a registered output
// depends on hrp_pkg
module hrp_back
    import hrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_bundle i_q_data,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_out    o_result
);
    t_bundle    r_cur;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       last, adv, load;

    assign last    = {1'b0, r_idx} == r_cur.count - 3'd1;
    assign adv     = r_valid && i_pop && last;
    assign load    = i_q_valid && (!r_valid || adv);
    assign o_q_rd  = load;
    assign o_empty = !r_valid;
    assign o_result = r_cur.res[r_idx];

    always_ff @(posedge i_clk) begin
        if (load) r_cur <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (adv) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

FILE: hdl/http_request_header_parser.sv
// top level of the http request header parser
// depends on hrp_pkg, hrp_front, hrp_queue, hrp_back
//
// Input channel: one header byte per beat with a final flag, taken when push
// is high and full is low. Result channel: the oldest result sits on o_result
// while empty is low and leaves on a beat with pop high.
// A byte yields zero to four results: verb, path, version, header fields,
// and a done event closing the request. run_end flags the last result of a
// byte. A final byte (or a zero byte) closes the request; after a final byte
// the parser starts a new request at offset zero.
// Throughput: one byte per cycle while full is low; the front end parses each
// byte combinationally and hands a bundle of results to a four-entry queue. The
// back end drains one result per cycle while pop is high, and the queue absorbs
// the difference when bytes yield several results.
// Path: a result is registered in the queue and then in the back end's result
// register, which drives the output ports.
// Reset (synchronous, active low) empties the queue and output and returns
// the parser to the start of a request. When the receiver stalls, results
// hold and the queue fills; full rises once four bundles wait.
module http_request_header_parser
    import hrp_pkg::*;
#(
    parameter int HEADER_SLOTS = HRP_HEADER_SLOTS,
    parameter int BUFFER_BYTES = HRP_BUFFER_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);
    logic    accept, q_valid, q_rd;
    t_bundle f_bundle, q_data;

    assign accept = push && !full;

    hrp_front #(
        .HEADER_SLOTS(HEADER_SLOTS),
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .o_bundle(f_bundle)
    );

    hrp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (accept && f_bundle.count != 3'd0),
        .i_data (f_bundle),
        .o_full (full),
        .i_rd   (q_rd),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    hrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_data),
        .o_q_rd   (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

FILE: hdl/hrp_checker.sv
// port level checks of the http request header parser, bound to the top level
// depends on hrp_pkg and assert_macros.svh
`include "assert_macros.svh"
module hrp_checker
    import hrp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic pop,
    input logic empty,
    input logic full,
    input t_out o_result
);
    logic done_beat, done_zero;

    assign done_beat = !empty &&
                       (o_result.event_kind == EV_OK || o_result.event_kind == EV_FAIL);
    assign done_zero = o_result.field_offset == 12'd0 && o_result.field_length == 13'd0;

    `HRP_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> empty && !full)
    `HRP_ASSERT(a_result_holds, !empty && !pop |=> !empty)
    `HRP_ASSERT(a_payload_holds, !empty && !pop |=> $stable(o_result))
    `HRP_ASSERT(a_kind_range, !empty |-> o_result.event_kind <= EV_FAIL)
    `HRP_ASSERT(a_done_last, done_beat |-> o_result.run_end && done_zero)

endmodule

bind http_request_header_parser hrp_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .pop     (pop),
    .empty   (empty),
    .full    (full),
    .o_result(o_result)
);
